>>> hdl/key_velocity_region_select_unit_macros.svh
// Assertion macros for the key/velocity region select block.
// Used by hdl/key_velocity_region_select_unit.sv; expects clk and rst_n in scope.
`ifndef KEY_VELOCITY_REGION_SELECT_UNIT_MACROS_SVH
`define KEY_VELOCITY_REGION_SELECT_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KVRS_CHECK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KVRS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/kvrs_pkg.sv
// Shared constants and types for the key/velocity region select block.
// No dependencies; imported by kvrs_mod_unit and the top level.
`default_nettype none

package kvrs_pkg;

  localparam int MAX_REGIONS  = 32;
  localparam int COUNTER_BITS = 32;
  localparam int NOTE_TOP     = 127;

  localparam int IDX_W  = $clog2(MAX_REGIONS);
  localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
  localparam int KEY_W  = $clog2(NOTE_TOP + 1);
  localparam int NOTES  = NOTE_TOP + 1;
  localparam int STEP_W = $clog2(COUNTER_BITS + 1);

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [6:0] lo_n;
    logic [6:0] hi_n;
    logic [6:0] lo_v;
    logic [6:0] hi_v;
    logic       rr;
  } region_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

`default_nettype wire

>>> hdl/kvrs_mod_unit.sv
// Bit-serial restoring remainder unit: counter value mod round-robin match count.
// Depends on kvrs_pkg for widths and the status struct.
`default_nettype none

module kvrs_mod_unit
  import kvrs_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [COUNTER_BITS-1:0] dividend,
  input  wire logic [CNT_W-1:0]        divisor,
  output mod_stat_t                    stat,
  output logic      [CNT_W-1:0]        remainder
);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [COUNTER_BITS-1:0] dvd_r, dvd_nxt;
  logic [CNT_W-1:0]        div_r, div_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic [CNT_W:0]          shifted;

  assign shifted = {rem_r, dvd_r[COUNTER_BITS-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      if (shifted >= {1'b0, div_r}) begin
        rem_nxt = CNT_W'(shifted - {1'b0, div_r});
      end else begin
        rem_nxt = shifted[CNT_W-1:0];
      end
      dvd_nxt  = {dvd_r[COUNTER_BITS-2:0], 1'b0};
      step_nxt = STEP_W'(step_r + 1'b1);
      if (step_r == STEP_W'(COUNTER_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

>>> hdl/key_velocity_region_select_unit.sv
// Top level of the key/velocity region select block: region table, counters, sequencer.
// Depends on kvrs_pkg, kvrs_mod_unit and key_velocity_region_select_unit_macros.svh.
//
// One request is taken at a time; in_stall stays high until its result is in the output
// register. Add, clear and unused-mode requests and lookups of notes above the top go
// straight to the done state. A lookup walks the region table through its single
// registered read port, one entry per cycle; when several regions match and at least one
// of them is round-robin, a bit-serial remainder and a second walk of the table follow.
// Per-note counters sit in a 128-entry memory with a valid bit per note, so reset and
// clear empty them by clearing the valid bits and no clearing pass is needed.
`default_nettype none
`include "key_velocity_region_select_unit_macros.svh"

module key_velocity_region_select_unit
  import kvrs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_mode,
  input  wire logic [7:0]        in_key,
  input  wire logic [6:0]        in_strike,
  input  wire logic [6:0]        in_lo_note,
  input  wire logic [6:0]        in_hi_note,
  input  wire logic [6:0]        in_lo_velocity,
  input  wire logic [6:0]        in_hi_velocity,
  input  wire logic signed [7:0] in_rr_group,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_found,
  output logic [4:0]             out_region_index,
  output logic [5:0]             out_region_count,
  output logic                   out_rejected
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN1 = 5'b00010,
    ST_MOD   = 5'b00100,
    ST_SCAN2 = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  region_t                 table_mem [MAX_REGIONS];
  logic [COUNTER_BITS-1:0] ctr_mem [NOTES];
  logic [NOTES-1:0]        ctr_vld_r, ctr_vld_nxt;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        scan_r, scan_nxt;
  logic                    eval_v_r;
  logic [IDX_W-1:0]        eval_idx_r;
  region_t                 tbl_rd_r;
  logic [COUNTER_BITS-1:0] cnt_rd_r;

  logic [KEY_W-1:0]        key_r;
  logic [6:0]              strike_r;
  logic [CNT_W-1:0]        nmatch_r, nmatch_nxt;
  logic [CNT_W-1:0]        nrr_r, nrr_nxt;
  logic [IDX_W-1:0]        first_r, first_nxt;
  logic [CNT_W-1:0]        sel_r, sel_nxt;
  logic                    hit_r, hit_nxt;

  logic                    res_found_r, res_found_nxt;
  logic [IDX_W-1:0]        res_idx_r, res_idx_nxt;
  logic                    res_rej_r, res_rej_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_found_r;
  logic [4:0]              out_idx_r;
  logic [5:0]              out_count_r;
  logic                    out_rej_r;

  logic                    accept;
  logic                    scanning;
  logic                    issue;
  logic                    scan_done;
  logic                    match;
  logic                    tbl_wr;
  region_t                 tbl_wr_data;
  logic                    ctr_wr;
  logic [COUNTER_BITS-1:0] cnt_cur;
  logic                    mod_start;
  mod_stat_t               mod_stat;
  logic [CNT_W-1:0]        mod_rem;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign scanning  = (state_r == ST_SCAN1) || (state_r == ST_SCAN2);
  assign issue     = scanning && (scan_r < count_r);
  assign scan_done = scanning && !issue && !eval_v_r;
  assign cnt_cur   = ctr_vld_r[key_r] ? cnt_rd_r : '0;

  assign match = eval_v_r &&
                 (key_r >= tbl_rd_r.lo_n) && (key_r <= tbl_rd_r.hi_n) &&
                 (strike_r >= tbl_rd_r.lo_v) && (strike_r <= tbl_rd_r.hi_v);

  assign tbl_wr_data.lo_n = in_lo_note;
  assign tbl_wr_data.hi_n = in_hi_note;
  assign tbl_wr_data.lo_v = in_lo_velocity;
  assign tbl_wr_data.hi_v = in_hi_velocity;
  assign tbl_wr_data.rr   = !in_rr_group[7];

  kvrs_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (cnt_cur),
    .divisor   (nrr_r),
    .stat      (mod_stat),
    .remainder (mod_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    ctr_vld_nxt   = ctr_vld_r;
    nmatch_nxt    = nmatch_r;
    nrr_nxt       = nrr_r;
    first_nxt     = first_r;
    sel_nxt       = sel_r;
    hit_nxt       = hit_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    res_rej_nxt   = res_rej_r;
    out_valid_nxt = out_valid_r && out_stall;
    tbl_wr        = 1'b0;
    ctr_wr        = 1'b0;
    mod_start     = 1'b0;

    if (issue) begin
      scan_nxt = CNT_W'(scan_r + 1'b1);
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_found_nxt = 1'b0;
          res_idx_nxt   = '0;
          res_rej_nxt   = 1'b0;
          state_nxt     = ST_DONE;
          case (in_mode)
            MODE_ADD: begin
              if (count_r >= CNT_W'(MAX_REGIONS)) begin
                res_rej_nxt = 1'b1;
              end else begin
                tbl_wr    = 1'b1;
                count_nxt = CNT_W'(count_r + 1'b1);
              end
            end
            MODE_CLEAR: begin
              count_nxt   = '0;
              ctr_vld_nxt = '0;
            end
            MODE_LOOKUP: begin
              // notes above the top never match: skip the walk
              if (in_key <= 8'(NOTE_TOP)) begin
                scan_nxt   = '0;
                nmatch_nxt = '0;
                nrr_nxt    = '0;
                first_nxt  = '0;
                state_nxt  = ST_SCAN1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN1: begin
        if (match) begin
          if (nmatch_r == '0) begin
            first_nxt = eval_idx_r;
          end
          nmatch_nxt = CNT_W'(nmatch_r + 1'b1);
          if (tbl_rd_r.rr) begin
            nrr_nxt = CNT_W'(nrr_r + 1'b1);
          end
        end
        if (scan_done) begin
          if (nmatch_r == '0) begin
            state_nxt = ST_DONE;
          end else if ((nmatch_r == CNT_W'(1)) || (nrr_r == '0)) begin
            res_found_nxt = 1'b1;
            res_idx_nxt   = first_r;
            state_nxt     = ST_DONE;
          end else begin
            // advance this note's counter and start the remainder
            mod_start            = 1'b1;
            ctr_wr               = 1'b1;
            ctr_vld_nxt[key_r]   = 1'b1;
            state_nxt            = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (mod_stat.done) begin
          sel_nxt   = mod_rem;
          hit_nxt   = 1'b0;
          scan_nxt  = '0;
          state_nxt = ST_SCAN2;
        end
      end
      ST_SCAN2: begin
        if (match && tbl_rd_r.rr && !hit_r) begin
          if (sel_r == '0) begin
            hit_nxt     = 1'b1;
            res_idx_nxt = eval_idx_r;
          end else begin
            sel_nxt = CNT_W'(sel_r - 1'b1);
          end
        end
        if (scan_done) begin
          res_found_nxt = 1'b1;
          state_nxt     = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      eval_v_r    <= 1'b0;
      ctr_vld_r   <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      eval_v_r    <= issue;
      ctr_vld_r   <= ctr_vld_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
    end
    eval_idx_r  <= scan_r[IDX_W-1:0];
    nmatch_r    <= nmatch_nxt;
    nrr_r       <= nrr_nxt;
    first_r     <= first_nxt;
    sel_r       <= sel_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    res_rej_r   <= res_rej_nxt;
    if (accept) begin
      key_r    <= in_key[KEY_W-1:0];
      strike_r <= in_strike;
    end
    if ((state_r == ST_DONE) && (!out_valid_r || !out_stall)) begin
      out_found_r <= res_found_r;
      out_idx_r   <= 5'(res_idx_r);
      out_count_r <= 6'(count_r);
      out_rej_r   <= res_rej_r;
    end
  end

  // region table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      table_mem[count_r[IDX_W-1:0]] <= tbl_wr_data;
    end
    if (issue) begin
      tbl_rd_r <= table_mem[scan_r[IDX_W-1:0]];
    end
  end

  // per-note round-robin counters
  always_ff @(posedge clk) begin
    if (ctr_wr) begin
      ctr_mem[key_r] <= COUNTER_BITS'(cnt_cur + 1'b1);
    end
    if (accept) begin
      cnt_rd_r <= ctr_mem[in_key[KEY_W-1:0]];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_region_index = out_idx_r;
  assign out_region_count = out_count_r;
  assign out_rejected     = out_rej_r;

  `KVRS_CHECK_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_REGIONS), "region count overflow")
  `KVRS_CHECK_IMP(a_found_in_table, out_valid && out_found,
    6'(out_region_index) < out_region_count, "selected region beyond count")
  `KVRS_CHECK_IMP(a_reject_full, out_valid && out_rejected,
    out_region_count == 6'(MAX_REGIONS), "add rejected with room left")
  `KVRS_CHECK_IMP(a_rr_hit, (state_r == ST_SCAN2) && scan_done, hit_r || match,
    "round-robin walk ended without a selection")
  `KVRS_CHECK_IMP(a_mod_owner, mod_stat.busy || mod_stat.done, state_r == ST_MOD,
    "remainder active outside its state")
  `KVRS_CHECK_NEXT(a_add_grows,
    accept && (in_mode == MODE_ADD) && (count_r < CNT_W'(MAX_REGIONS)),
    count_r == CNT_W'($past(count_r) + 1'b1), "accepted add did not grow the table")

endmodule

`default_nettype wire
